>>> hdl/sawtc_pkg.sv
// Shared constants and types of the set-associative write-through cache.
package sawtc_pkg;

  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 4;
  localparam int DATA_W     = 64;
  localparam int MAX_SIZE   = 8;
  localparam int ADDR_LSB   = 0;
  localparam int SIZE_LSB   = ADDR_LSB + ADDR_W;
  localparam int WDATA_LSB  = SIZE_LSB + SIZE_W;
  localparam int IN_TDATA_W = 88;
  localparam int WAY_IDX_W  = 4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] way;
  } lkp_res_t;

endpackage

>>> hdl/sawtc_ram.sv
// Single-port synchronous RAM with registered read data.
module sawtc_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [1 << AW];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sawtc_lookup.sv
// Tag compare, age update and victim choice for one set row.
module sawtc_lookup #(
  parameter int NUM_WAYS = 4,
  parameter int TAG_W    = 6,
  parameter int AGE_BITS = 8,
  parameter int ENT_W    = 1 + AGE_BITS + TAG_W
) (
  input  logic [NUM_WAYS*ENT_W-1:0] row,
  input  logic [TAG_W-1:0]          tag,
  input  logic                      kind,
  output sawtc_pkg::lkp_res_t       res,
  output logic [NUM_WAYS*ENT_W-1:0] new_row
);
  import sawtc_pkg::*;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  always_comb begin
    logic                 hit_any;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 found;
    logic [WAY_IDX_W-1:0] victim;
    logic [AGE_BITS-1:0]  best;
    logic                 v;
    logic [AGE_BITS-1:0]  age;
    logic [TAG_W-1:0]     t;
    hit_any = 1'b0;
    hit_way = '0;
    found   = 1'b0;
    victim  = '0;
    best    = '0;
    new_row = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      {v, age, t} = row[w*ENT_W +: ENT_W];
      if (v && t == tag) begin
        hit_any = 1'b1;
        hit_way = WAY_IDX_W'(w);
        age     = '0;
      end else if (age < AGE_MAX) begin
        age = age + 1'b1;
      end
      new_row[w*ENT_W +: ENT_W] = {v, age, t};
    end
    // First invalid way wins; otherwise the first way with the largest nonzero age,
    // judged on the ages after this access has raised them.
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && !row[w*ENT_W + ENT_W - 1]) begin
        found  = 1'b1;
        victim = WAY_IDX_W'(w);
      end
    end
    if (!found) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        age = new_row[w*ENT_W + TAG_W +: AGE_BITS];
        if (age > best) begin
          best   = age;
          victim = WAY_IDX_W'(w);
        end
      end
    end
    if (kind == KIND_LOAD && !hit_any) begin
      new_row[32'(victim)*ENT_W +: ENT_W] = {1'b1, {AGE_BITS{1'b0}}, tag};
    end
    res.hit = hit_any;
    res.way = hit_any ? hit_way : victim;
  end

endmodule

>>> hdl/set_assoc_write_through_cache.sv
// Set-associative write-through cache with no write allocate and age-based replacement.
// Input channel (in_*): one word per access; in_tuser is the kind (0 load, 1 store),
// in_tdata carries address, size in bytes and store bytes. Output channel (out_*):
// one word per access; out_tuser is the hit flag, out_tdata the loaded bytes.
// After reset the block sweeps the backing memory and the tag store to zero, one
// entry a cycle, over max(MEM_BYTES, NUM_SETS) entries; in_tready stays low
// meanwhile. Each access then goes through these steps: it is accepted while the
// tag store is read, then tags are compared and the tag row is written back, then
// per-byte work runs on single-port byte memories, and last the result moves into
// the output register. A load hit reads its bytes from the line, a store writes its
// bytes through to backing memory (and to the line on a hit), and a load miss fills
// the line one byte a cycle from backing memory.
// Only one access is in flight; the result sits in an output register, so a
// stalled receiver holds that result while the next access is already taken in.
// A finished result waits inside the block until the output register is free.
module set_assoc_write_through_cache #(
  parameter int MEM_BYTES   = 65536,
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 16,
  parameter int AGE_BITS    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // address [15:0], size_bytes [19:16], write_data [83:20], zero [87:84]
  input  logic [sawtc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind [0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_data [63:0]
  output logic [sawtc_pkg::DATA_W-1:0]       out_tdata,
  // hit [0]
  output logic                               out_tuser
);
  import sawtc_pkg::*;

  localparam int MEM_AW  = $clog2(MEM_BYTES);
  localparam int OFF_W   = $clog2(BLOCK_BYTES);
  localparam int SET_LOG = $clog2(NUM_SETS);
  localparam int SET_W   = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_RAW = MEM_AW - OFF_W - SET_LOG;
  localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int ENT_W   = 1 + AGE_BITS + TAG_W;
  localparam int ROW_W   = NUM_WAYS * ENT_W;
  localparam int LINE_AW = SET_W + WAY_W + OFF_W;
  localparam int CNT_W   = OFF_W + 1;
  localparam int CLR_N   = (MEM_BYTES > NUM_SETS) ? MEM_BYTES : NUM_SETS;
  localparam int CLR_W   = $clog2(CLR_N);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_FILL  = 7'b0001000,
    S_RD    = 7'b0010000,
    S_WR    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CLR_W-1:0]    clr_r;
  logic                kind_r;
  logic [MEM_AW-1:0]   addr_r;
  logic [CNT_W-1:0]    size_r;
  logic [DATA_W-1:0]   wdata_r;
  logic                hit_r;
  logic [WAY_W-1:0]    way_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DATA_W-1:0]   rdata_r;
  logic                out_tvalid_r;
  logic                out_hit_r;
  logic [DATA_W-1:0]   out_data_r;

  logic [ADDR_W-1:0]   in_addr;
  logic [SIZE_W-1:0]   in_size;
  logic [MEM_AW-1:0]   in_addr_m;
  logic [OFF_W-1:0]    in_off;
  logic [SIZE_W-1:0]   size8;
  logic [CNT_W-1:0]    avail;
  logic [CNT_W-1:0]    size_nxt;
  logic                in_acc;

  logic [SET_W-1:0]    set_in, set_r;
  logic [TAG_W-1:0]    tag_r;
  logic [OFF_W-1:0]    off_r;

  logic                meta_we;
  logic [SET_W-1:0]    meta_addr;
  logic [ROW_W-1:0]    meta_wdata, meta_q, new_row;
  lkp_res_t            lkp;

  logic                line_we;
  logic [OFF_W-1:0]    line_off;
  logic [7:0]          line_wdata, line_q;

  logic                bk_we;
  logic [MEM_AW-1:0]   bk_addr;
  logic [7:0]          bk_wdata, bk_q;

  logic [7:0]          wbyte;
  logic [OFF_W-1:0]    fill_b;
  logic [CNT_W-1:0]    fill_rel;
  logic                fill_take;
  logic                out_load;

  assign in_addr   = in_tdata[ADDR_LSB +: ADDR_W];
  assign in_size   = in_tdata[SIZE_LSB +: SIZE_W];
  assign in_addr_m = MEM_AW'(in_addr);
  assign in_off    = OFF_W'(in_addr_m);
  assign size8     = (in_size > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : in_size;
  assign avail     = CNT_W'(BLOCK_BYTES) - CNT_W'(in_off);
  assign size_nxt  = (CNT_W'(size8) > avail) ? avail : CNT_W'(size8);
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign set_in = SET_W'((32'(in_addr_m) / BLOCK_BYTES) % NUM_SETS);
  assign set_r  = SET_W'((32'(addr_r) / BLOCK_BYTES) % NUM_SETS);
  assign tag_r  = TAG_W'(32'(addr_r) >> (OFF_W + SET_LOG));
  assign off_r  = OFF_W'(addr_r);

  // Tag, valid and age of all ways of a set live in one row.
  assign meta_addr  = (state_r == S_CLEAR) ? SET_W'(clr_r) :
                      (state_r == S_IDLE)  ? set_in : set_r;
  assign meta_we    = ((state_r == S_CLEAR) && (32'(clr_r) < NUM_SETS)) ||
                      (state_r == S_LOOK);
  assign meta_wdata = (state_r == S_CLEAR) ? '0 : new_row;

  sawtc_ram #(.WIDTH(ROW_W), .AW(SET_W)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .addr  (meta_addr),
    .wdata (meta_wdata),
    .rdata (meta_q)
  );

  sawtc_lookup #(
    .NUM_WAYS (NUM_WAYS),
    .TAG_W    (TAG_W),
    .AGE_BITS (AGE_BITS),
    .ENT_W    (ENT_W)
  ) u_lookup (
    .row     (meta_q),
    .tag     (tag_r),
    .kind    (kind_r),
    .res     (lkp),
    .new_row (new_row)
  );

  assign wbyte    = wdata_r[{cnt_r[2:0], 3'b000} +: 8];
  assign fill_b   = OFF_W'(cnt_r - 1'b1);
  assign fill_rel = CNT_W'(fill_b) - CNT_W'(off_r);
  assign fill_take = (cnt_r != '0) && (CNT_W'(fill_b) >= CNT_W'(off_r)) &&
                     (fill_rel < size_r);

  always_comb begin
    line_off = off_r + OFF_W'(cnt_r);
    if (state_r == S_FILL) begin
      line_off = fill_b;
    end
  end
  assign line_we    = ((state_r == S_FILL) && (cnt_r != '0)) ||
                      ((state_r == S_WR) && hit_r);
  assign line_wdata = (state_r == S_FILL) ? bk_q : wbyte;

  sawtc_ram #(.WIDTH(8), .AW(LINE_AW)) u_line (
    .clk   (clk),
    .we    (line_we),
    .addr  ({set_r, way_r, line_off}),
    .wdata (line_wdata),
    .rdata (line_q)
  );

  always_comb begin
    bk_addr = addr_r + MEM_AW'(cnt_r);
    if (state_r == S_CLEAR) begin
      bk_addr = MEM_AW'(clr_r);
    end else if (state_r == S_FILL) begin
      bk_addr = {addr_r[MEM_AW-1:OFF_W], OFF_W'(cnt_r)};
    end
  end
  assign bk_we    = ((state_r == S_CLEAR) && (32'(clr_r) < MEM_BYTES)) ||
                    (state_r == S_WR);
  assign bk_wdata = (state_r == S_CLEAR) ? 8'h00 : wbyte;

  sawtc_ram #(.WIDTH(8), .AW(MEM_AW)) u_backing (
    .clk   (clk),
    .we    (bk_we),
    .addr  (bk_addr),
    .wdata (bk_wdata),
    .rdata (bk_q)
  );

  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == CLR_W'(CLR_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (kind_r == KIND_STORE) begin
          state_nxt = (size_r == '0) ? S_OUT : S_WR;
        end else begin
          state_nxt = lkp.hit ? S_RD : S_FILL;
        end
      end
      S_FILL: begin
        if (cnt_r == CNT_W'(BLOCK_BYTES)) state_nxt = S_OUT;
      end
      S_RD: begin
        if (cnt_r == size_r) state_nxt = S_OUT;
      end
      S_WR: begin
        if (cnt_r + 1'b1 == size_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_tuser;
      addr_r  <= in_addr_m;
      size_r  <= size_nxt;
      wdata_r <= in_tdata[WDATA_LSB +: DATA_W];
      rdata_r <= '0;
    end
    if (state_r == S_LOOK) begin
      hit_r <= lkp.hit;
      way_r <= WAY_W'(lkp.way);
      cnt_r <= '0;
    end
    if (state_r == S_FILL) begin
      if (fill_take) begin
        rdata_r[{fill_rel[2:0], 3'b000} +: 8] <= bk_q;
      end
      if (cnt_r != CNT_W'(BLOCK_BYTES)) cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == S_RD) begin
      if (cnt_r != '0) begin
        rdata_r[{3'(cnt_r - 1'b1), 3'b000} +: 8] <= line_q;
      end
      if (cnt_r != size_r) cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == S_WR) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (out_load) begin
      out_hit_r  <= hit_r;
      out_data_r <= rdata_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("input accepted during the clearing pass");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_LOOK))
    else $error("accepted access did not proceed to tag lookup");

  a_store_miss_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WR) && !hit_r) |-> !line_we)
    else $error("store miss wrote the line store");

  a_read_within_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (cnt_r <= size_r))
    else $error("line read ran past the access size");

endmodule
